FILE: rtl/fdbe_pkg.sv
// ----------------------------------------------------------------------------
// fdbe_pkg: shared types and dictionary lookups for the digram byte encoder
// Result record, the per-cycle push bundle toward the output queue, error
// codes, and the bigram and single-character dictionary functions.
// ----------------------------------------------------------------------------
package fdbe_pkg;

	// error codes carried in error_kind
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
	localparam logic [1:0] ERR_TOO_LONG = 2'd2;

	// output queue geometry
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	// one result item
	typedef struct packed {
		logic [7:0] code;
		logic [1:0] error_kind;
		logic       final_result;
	} result_t;

	// results produced by one input byte, in order
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} push_t;

	// dictionary lookup answer
	typedef struct packed {
		logic       hit;
		logic [7:0] code;
	} lookup_t;

	// listed bigram codes 0-9
	function automatic lookup_t bigram_lookup(input logic [7:0] a, input logic [7:0] b);
		lookup_t r;
		r.hit  = 1'b1;
		r.code = 8'd0;
		case ({a, b})
			"th":    r.code = 8'd0;
			"he":    r.code = 8'd1;
			"in":    r.code = 8'd2;
			"er":    r.code = 8'd3;
			"an":    r.code = 8'd4;
			"re":    r.code = 8'd5;
			"on":    r.code = 8'd6;
			"en":    r.code = 8'd7;
			"at":    r.code = 8'd8;
			"es":    r.code = 8'd9;
			default: r.hit  = 1'b0;
		endcase
		return r;
	endfunction

	// single character codes 10-85
	function automatic lookup_t char_lookup(input logic [7:0] c);
		lookup_t r;
		r.hit  = 1'b1;
		r.code = 8'd0;
		case (c) inside
			" ":          r.code = 8'd10;
			"\n":         r.code = 8'd11;
			"\t":         r.code = 8'd12;
			["0":"9"]:    r.code = 8'd13 + (c - "0");
			["a":"z"]:    r.code = 8'd23 + (c - "a");
			["A":"Z"]:    r.code = 8'd49 + (c - "A");
			".":          r.code = 8'd75;
			",":          r.code = 8'd76;
			"!":          r.code = 8'd77;
			"?":          r.code = 8'd78;
			";":          r.code = 8'd79;
			":":          r.code = 8'd80;
			"'":          r.code = 8'd81;
			"\"":         r.code = 8'd82;
			"-":          r.code = 8'd83;
			"(":          r.code = 8'd84;
			")":          r.code = 8'd85;
			default:      r.hit  = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/fdbe_core.sv
// ----------------------------------------------------------------------------
// fdbe_core: input register and single-pass encode step
// Registers each byte, matches it against the held byte and the dictionary,
// updates the message state and hands zero to two results to the queue.
// ----------------------------------------------------------------------------
module fdbe_core #(
	parameter int MAX_MESSAGE_BYTES = 65535
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      in_byte,
	input  logic            end_of_message,
	input  logic            room,
	output fdbe_pkg::push_t push
);
	import fdbe_pkg::*;

	localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 1) < 1 ? 1
		: $clog2(MAX_MESSAGE_BYTES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MESSAGE_BYTES);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eom_s1;

	// message state
	logic [7:0]       held_byte_q, held_byte_d;
	logic [7:0]       held_code_q, held_code_d;
	logic             held_valid_q, held_valid_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             failed_q, failed_d;

	logic    fire;
	logic    head;
	lookup_t bg;
	lookup_t ch;
	result_t head_res;
	logic    head_push;

	assign fire     = valid_s1 & room;
	assign in_stall = valid_s1 & ~room;

	// input register, refilled whenever the stage empties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= in_byte;
			eom_s1  <= end_of_message;
		end
	end

	assign bg = bigram_lookup(held_byte_q, byte_s1);
	assign ch = char_lookup(byte_s1);

	// encode step and next state
	always_comb begin
		held_byte_d  = held_byte_q;
		held_code_d  = held_code_q;
		held_valid_d = held_valid_q;
		count_d      = count_q;
		failed_d     = failed_q;
		push         = '0;
		head         = 1'b0;
		head_push    = 1'b0;
		head_res     = '0;
		if (fire) begin
			if (failed_q) begin
				// dropping the rest of a failed message
			end else if (count_q == CNT_MAX) begin
				push.num        = 2'd1;
				push.r0         = '{code: 8'd0, error_kind: ERR_TOO_LONG, final_result: 1'b1};
				held_valid_d    = 1'b0;
				failed_d        = 1'b1;
			end else begin
				count_d = count_q + CNT_W'(1);
				head    = 1'b1;
				// held byte first: bigram or its own character code
				if (held_valid_q) begin
					held_valid_d = 1'b0;
					push.num     = 2'd1;
					if (bg.hit) begin
						push.r0 = '{code: bg.code, error_kind: ERR_NONE,
							final_result: eom_s1};
						head    = 1'b0;
					end else begin
						push.r0 = '{code: held_code_q, error_kind: ERR_NONE,
							final_result: 1'b0};
					end
				end
				// the new byte when it was not absorbed by a bigram
				if (head) begin
					if (!ch.hit) begin
						head_push = 1'b1;
						head_res  = '{code: 8'd0, error_kind: ERR_UNKNOWN, final_result: 1'b1};
						failed_d  = 1'b1;
					end else if (eom_s1) begin
						head_push = 1'b1;
						head_res  = '{code: ch.code, error_kind: ERR_NONE, final_result: 1'b1};
					end else begin
						held_byte_d  = byte_s1;
						held_code_d  = ch.code;
						held_valid_d = 1'b1;
					end
				end
				if (head_push) begin
					if (push.num == 2'd0) begin
						push.r0 = head_res;
					end else begin
						push.r1 = head_res;
					end
					push.num = push.num + 2'd1;
				end
			end
			// final byte returns to the idle message state
			if (eom_s1) begin
				held_byte_d  = 8'd0;
				held_valid_d = 1'b0;
				count_d      = '0;
				failed_d     = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q  <= 8'd0;
			held_valid_q <= 1'b0;
			count_q      <= '0;
			failed_q     <= 1'b0;
		end else begin
			held_byte_q  <= held_byte_d;
			held_valid_q <= held_valid_d;
			count_q      <= count_d;
			failed_q     <= failed_d;
		end
	end

	always_ff @(posedge clk) begin
		held_code_q <= held_code_d;
	end

`ifndef SYNTH
	// the first of two results never closes the message
	a_two_first_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		push.num == 2'd2 |-> !push.r0.final_result && push.r0.error_kind == ERR_NONE)
		else $error("first of two results marked final or error");

	// a failed message stays silent until its final byte
	a_failed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |-> push.num == 2'd0)
		else $error("result produced while dropping a failed message");

	// no results without a transfer out of the input stage
	a_push_needs_fire: assert property (@(posedge clk) disable iff (!arst_n)
		push.num != 2'd0 |-> fire)
		else $error("results pushed without an item");

	// a held byte always refers to a dictionary character
	a_held_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> held_code_q >= 8'd10 && held_code_q <= 8'd85)
		else $error("held byte code out of range");
`endif

endmodule

FILE: rtl/fdbe_queue.sv
// ----------------------------------------------------------------------------
// fdbe_queue: small result queue with dual push
// Takes up to two results a cycle from the encode step and presents one
// result at a time on the output channel.
// ----------------------------------------------------------------------------
module fdbe_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  fdbe_pkg::push_t push,
	output logic            room,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      code,
	output logic [1:0]      error_kind,
	output logic            final_result
);
	import fdbe_pkg::*;

	result_t              mem_q [Q_DEPTH];
	logic [Q_AW-1:0]      rd_q;
	logic [Q_AW-1:0]      wr_q;
	logic [Q_AW-1:0]      wr_nx;
	logic [Q_CW-1:0]      cnt_q;
	logic                 pop;

	assign wr_nx     = wr_q + Q_AW'(1);
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid & ~out_stall;
	assign room      = cnt_q <= Q_CW'(Q_DEPTH - 2);

	assign code         = mem_q[rd_q].code;
	assign error_kind   = mem_q[rd_q].error_kind;
	assign final_result = mem_q[rd_q].final_result;

	// storage, one or two entries per cycle
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_nx] <= push.r1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + Q_AW'(push.num);
			if (pop) begin
				rd_q <= rd_q + Q_AW'(1);
			end
			cnt_q <= cnt_q + Q_CW'(push.num) - Q_CW'(pop);
		end
	end

`ifndef SYNTH
	// fill level never passes the depth
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CW'(Q_DEPTH))
		else $error("result queue overflow");

	// pushes only arrive when two slots are free
	a_push_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.num != 2'd0 |-> room)
		else $error("push into a full result queue");

	// a lone transfer out drops the level by one
	a_pop_level: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.num == 2'd0 |=> cnt_q == $past(cnt_q) - Q_CW'(1))
		else $error("queue level wrong after transfer");
`endif

endmodule

FILE: rtl/fixed_digram_byte_encoder.sv
// ----------------------------------------------------------------------------
// fixed_digram_byte_encoder: static digram coding of a byte stream
// Encodes message bytes into 8-bit codes from a fixed bigram and
// character dictionary, with error results for unknown bytes and overlong
// messages.
// ----------------------------------------------------------------------------
// Usage:
// - input channel: in_valid / in_stall with in_byte and end_of_message;
//   one byte per transfer, end_of_message on the final byte of a message
// - output channel: out_valid / out_stall with code, error_kind and
//   final_result; one result per transfer
// - one byte is accepted every cycle as long as the output side keeps up;
//   a byte gives zero, one or two results, so when results come out slower
//   than one a cycle the four-entry result queue fills and in_stall rises
// - a byte is registered in the input stage and encoded from there; its
//   results are then registered in the result queue, which drives the
//   output channel
// - a known byte that does not end the message is held and produces its code
//   only when the next byte arrives, which may be the final byte of the message
// - reset clears the input stage, the result queue and the message state;
//   no clearing pass is needed, input is taken right after reset
// - while out_stall is high the presented result holds and the queue keeps
//   absorbing results until fewer than two slots remain
// ----------------------------------------------------------------------------
module fixed_digram_byte_encoder #(
	parameter int MAX_MESSAGE_BYTES = 65535
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_message,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] code,
	output logic [1:0] error_kind,
	output logic       final_result
);
	import fdbe_pkg::*;

	push_t push;
	logic  room;

	// encode step
	fdbe_core #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.end_of_message (end_of_message),
		.room           (room),
		.push           (push)
	);

	// result queue toward the output channel
	fdbe_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code         (code),
		.error_kind   (error_kind),
		.final_result (final_result)
	);

endmodule

FILE: tb/fdbe_checker.sv
// ----------------------------------------------------------------------------
// fdbe_checker: result predictor and scoreboard for the digram byte encoder
// Watches both channels of the encoder. Every byte transfer is run through
// a cycle-free model of the dictionary coder, and the codes it should give
// are queued. Every result transfer is compared field by field against the
// oldest queued code. Mismatches and unexpected results are reported and
// counted for the testbench top.
// ----------------------------------------------------------------------------
module fdbe_checker #(
	parameter int MSG_LIMIT = 65535
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_message,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] code,
	input  logic [1:0] error_kind,
	input  logic       final_result,
	output int         mismatches,
	output int         outstanding,
	output int         results_checked,
	output int         bigram_codes,
	output int         error_results
);
	import fdbe_pkg::*;

	// bigrams in code order, two characters each
	localparam logic [8*20-1:0] PAIRS = "thheineranreonenates";
	// single characters in code order, starting at code 10
	localparam logic [8*76-1:0] SYMBOLS =
		" \n\t0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.,!?;:'\"-()";

	// model state of the message in progress
	logic [7:0]  held_byte;
	logic        held_valid;
	logic [16:0] byte_count;
	logic        dropping;

	result_t expected_codes[$];
	result_t want;

	// character code of a byte, -1 when it is not in the dictionary
	function automatic int symbol_code(input logic [7:0] c);
		for (int k = 0; k < 76; k++)
			if (SYMBOLS[8*(75-k) +: 8] == c)
				return k + 10;
		return -1;
	endfunction

	task automatic push_code(input logic [7:0] c, input logic [1:0] kind, input logic fin);
		result_t r;
		r.code         = c;
		r.error_kind   = kind;
		r.final_result = fin;
		expected_codes.push_back(r);
	endtask

	task automatic restart_message();
		held_byte  = 8'd0;
		held_valid = 1'b0;
		byte_count = 17'd0;
		dropping   = 1'b0;
	endtask

	// codes caused by one byte of a message
	task automatic encode_byte(input logic [7:0] b, input logic eom);
		int   pair;
		int   sym;
		logic consumed;
		pair     = -1;
		consumed = 1'b0;
		if (!dropping) begin
			byte_count = byte_count + 17'd1;
			if (byte_count > MSG_LIMIT) begin
				// overlong message: held byte is lost, rest is dropped
				push_code(8'd0, ERR_TOO_LONG, 1'b1);
				held_valid = 1'b0;
				dropping   = 1'b1;
			end else begin
				// held byte either pairs up with this one or goes out alone
				if (held_valid) begin
					for (int k = 0; k < 10; k++)
						if (pair < 0 && PAIRS[8*(19-2*k) +: 8] == held_byte &&
						    PAIRS[8*(18-2*k) +: 8] == b)
							pair = k;
					held_valid = 1'b0;
					if (pair >= 0) begin
						push_code(8'(pair), ERR_NONE, eom);
						consumed = 1'b1;
					end else begin
						push_code(8'(symbol_code(held_byte)), ERR_NONE, 1'b0);
					end
				end
				// this byte on its own: unknown, flushed or held
				if (!consumed) begin
					sym = symbol_code(b);
					if (sym < 0) begin
						push_code(8'd0, ERR_UNKNOWN, 1'b1);
						dropping = 1'b1;
					end else if (eom) begin
						push_code(8'(sym), ERR_NONE, 1'b1);
					end else begin
						held_byte  = b;
						held_valid = 1'b1;
					end
				end
			end
		end
		if (eom)
			restart_message();
	endtask

	// predict on byte transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_message();
			expected_codes.delete();
			mismatches      <= 0;
			outstanding     <= 0;
			results_checked <= 0;
			bigram_codes    <= 0;
			error_results   <= 0;
		end else begin
			if (in_valid && !in_stall)
				encode_byte(in_byte, end_of_message);
			if (out_valid && !out_stall) begin
				results_checked <= results_checked + 1;
				if (error_kind != ERR_NONE)
					error_results <= error_results + 1;
				else if (code < 8'd10)
					bigram_codes <= bigram_codes + 1;
				if (expected_codes.size() == 0) begin
					$display("%0t: unexpected result code %0d kind %0d final %0b",
						$time, code, error_kind, final_result);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_codes.pop_front();
					if (want.code !== code || want.error_kind !== error_kind ||
					    want.final_result !== final_result) begin
						$display("%0t: mismatch: expected code %0d kind %0d final %0b, got code %0d kind %0d final %0b",
							$time, want.code, want.error_kind, want.final_result,
							code, error_kind, final_result);
						mismatches <= mismatches + 1;
					end
				end
			end
			outstanding <= expected_codes.size();
		end
	end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the digram byte encoder
// Sends a short directed run through all bigrams and the unknown-byte
// cases, then random messages under four idle and stall mixes with one
// long receiver hold-off. The checker beside the encoder predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MSG_LIMIT     = 65535;
	localparam int RANDOM_BYTES  = 900;
	localparam int CYCLE_LIMIT   = 100000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;

	localparam logic [8*20-1:0] ALL_PAIRS      = "thheineranreonenates";
	localparam logic [8*9-1:0]  COMMON_LETTERS = "thenirsao";

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       in_valid       = 1'b0;
	logic [7:0] in_byte        = 8'd0;
	logic       end_of_message = 1'b0;
	logic       out_stall      = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] code;
	logic [1:0] error_kind;
	logic       final_result;

	logic holding     = 1'b0;
	int   idle_pct    = 0;
	int   stall_pct   = 0;
	int   bytes_sent  = 0;
	int   cycle_count = 0;

	int mismatches;
	int outstanding;
	int results_checked;
	int bigram_codes;
	int error_results;

	fixed_digram_byte_encoder #(
		.MAX_MESSAGE_BYTES(MSG_LIMIT)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.end_of_message(end_of_message),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code          (code),
		.error_kind    (error_kind),
		.final_result  (final_result)
	);

	fdbe_checker #(
		.MSG_LIMIT(MSG_LIMIT)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.code           (code),
		.error_kind     (error_kind),
		.final_result   (final_result),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.results_checked(results_checked),
		.bigram_codes   (bigram_codes),
		.error_results  (error_results)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycle_count, outstanding);
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stalls plus the long hold-off
	always @(posedge clk)
		out_stall <= holding || ($urandom_range(99) < stall_pct);

	// mostly text with frequent bigram letters; clean keeps to lowercase
	function automatic logic [7:0] pick_byte(input logic clean);
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return COMMON_LETTERS[8*$urandom_range(8) +: 8];
		if (clean || r < 65)
			return 8'($urandom_range("a", "z"));
		if (r < 75)
			return 8'($urandom_range("A", "Z"));
		if (r < 81)
			return 8'($urandom_range("0", "9"));
		if (r < 88) begin
			case ($urandom_range(2))
				0:       return " ";
				1:       return "\n";
				default: return "\t";
			endcase
		end
		if (r < 97)
			return 8'($urandom_range(33, 126));
		return 8'($urandom);
	endfunction

	// one byte transfer, after an optional idle stretch
	task automatic send_byte(input logic [7:0] b, input logic eom);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		in_valid       <= 1'b1;
		in_byte        <= b;
		end_of_message <= eom;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
	endtask

	// stimulus
	initial begin
		int target;
		int len;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all ten bigrams back to back, last one closing the message
		for (int i = 0; i < 20; i++)
			send_byte(ALL_PAIRS[8*(19-i) +: 8], i == 19);
		// unknown byte behind a held one, then dropped bytes to the end
		send_byte("q", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte("x", 1'b0);
		send_byte(")", 1'b1);
		// unknown byte that is also the final byte
		send_byte(8'hFF, 1'b1);

		// random messages under four idle and stall mixes
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
					// receiver holds off while bytes keep coming
					fork
						begin
							holding <= 1'b1;
							repeat (HOLD_CYCLES) @(posedge clk);
							holding <= 1'b0;
						end
					join_none
				end
				1: begin
					idle_pct  = 82;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 82;
				end
				default: begin
					idle_pct  = 14;
					stall_pct = 14;
				end
			endcase
			target = bytes_sent + RANDOM_BYTES / 4;
			while (bytes_sent < target) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
				for (int i = 0; i < len; i++)
					send_byte(pick_byte(1'b0), i == len - 1);
			end
		end

		idle_pct  = 0;
		stall_pct = 0;

		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d bytes in %0d cycles; %0d results checked, %0d bigram codes, %0d errors",
			bytes_sent, cycle_count, results_checked, bigram_codes, error_results);
		$display("mixes: free flow with a receiver hold-off, sparse sender, heavy stall, light both");
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
